FILE: rtl/jsu_pkg.sv
// Shared types, codes and helper functions of the JSON string unescaper.
package jsu_pkg;

   localparam int LEN_BITS   = 16;
   localparam int FIFO_DEPTH = 4;   // power of two
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOMEM = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   // up to four bytes of one character, first byte in slot 0
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      n;
   } jsu_utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } jsu_hex_type;

   // one entry of the front-to-back queue
   typedef struct packed {
      logic [3:0][7:0]       bytes;
      logic [2:0]            n_bytes;
      logic                  has_done;
      logic [1:0]            status;
      logic [LEN_BITS-1:0]   base_len;
   } jsu_cmd_type;

   function automatic jsu_hex_type hex_digit(input logic [7:0] c);
      jsu_hex_type r;
      r.ok    = 1'b1;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.value = 4'(c - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic jsu_utf8_type raw_byte(input logic [7:0] b);
      jsu_utf8_type r;
      r.bytes    = '0;
      r.bytes[0] = b;
      r.n        = 3'd1;
      return r;
   endfunction

   function automatic jsu_utf8_type utf8_encode(input logic [20:0] cp);
      jsu_utf8_type r;
      r.bytes = '0;
      if (cp < 21'h80) begin
         r.bytes[0] = cp[7:0];
         r.n = 3'd1;
      end else if (cp < 21'h800) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.n = 3'd2;
      end else if (cp < 21'h10000) begin
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
         r.n = 3'd3;
      end else begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.n = 3'd4;
      end
      return r;
   endfunction

endpackage

FILE: rtl/jsu_if.sv
// Request and response channel interfaces of the JSON string unescaper.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface jsu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [7:0]                    out_byte;
   logic                          out_valid;
   logic                          done_res;
   logic [1:0]                    status;
   logic [jsu_pkg::LEN_BITS-1:0]  out_length;

   modport source (output valid, output out_byte, output out_valid, output done_res,
                   output status, output out_length, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input done_res,
                   input status, input out_length, output ready);
endinterface

FILE: rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: escaped bytes in, UTF-8 bytes and status out.
// Takes one escaped source byte per request and returns unescaped bytes, one per
// response: plain bytes pass through, \" \\ \/ \r \n \t \b \f give one byte, \uXXXX
// gives 1 to 3 UTF-8 bytes and a surrogate pair gives 4. The last request of a string
// adds a status-only done response (ok, no_memory or bad_string) carrying the final
// length; on an error the string ends at once and later requests up to the last byte
// are dropped without response. The request side accepts one request every cycle as
// long as the 4-entry command queue between front and back end has room; the
// response side delivers one response per cycle while rsp_ch.ready is high, and the
// sustained rate is one request per cycle whenever responses average at most one per
// request. csr_wr_data sets the destination capacity (reset 65535, one byte kept for
// a terminator); write it only while idle. The front end holds the escape state and
// the byte count, so a request takes effect there in the cycle it is accepted; its
// responses pass through a queue entry and the back end's current-command register.
module json_string_unescape_utf8 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [jsu_pkg::LEN_BITS-1:0]  csr_wr_data,
   jsu_req_if.sink                       req_ch,
   jsu_rsp_if.source                     rsp_ch
);

   jsu_pkg::jsu_cmd_type push_cmd;
   jsu_pkg::jsu_cmd_type head_cmd;
   logic                 push;
   logic                 pop;
   logic                 full;
   logic                 empty;

   // front end: escape decoding, capacity check, command build
   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .q_full      (full),
      .q_push      (push),
      .q_cmd       (push_cmd)
   );

   // decouples request acceptance from response stalls
   jsu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (full),
      .pop       (pop),
      .pop_data  (head_cmd),
      .empty     (empty)
   );

   // back end: one response per beat out of the current command
   jsu_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_head  (head_cmd),
      .q_empty (empty),
      .q_pop   (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

FILE: rtl/jsu_front.sv
// Front end: accepts escaped bytes, tracks escape state, builds queue commands.
module jsu_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [jsu_pkg::LEN_BITS-1:0]  csr_wr_data,
   jsu_req_if.sink                       req_ch,
   input  logic                          q_full,
   output logic                          q_push,
   output jsu_pkg::jsu_cmd_type          q_cmd
);

   localparam logic [2:0] PH_NORMAL  = 3'd0;
   localparam logic [2:0] PH_ESC     = 3'd1;
   localparam logic [2:0] PH_HEX1    = 3'd2;
   localparam logic [2:0] PH_WANT_BS = 3'd3;
   localparam logic [2:0] PH_WANT_U  = 3'd4;
   localparam logic [2:0] PH_HEX2    = 3'd5;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [7:0] BYTE_BS  = 8'h08;
   localparam logic [7:0] BYTE_TAB = 8'h09;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_FF  = 8'h0C;
   localparam logic [7:0] BYTE_CR  = 8'h0D;

   localparam int LB = jsu_pkg::LEN_BITS;

   logic [LB-1:0]  capacity_ff;
   logic [2:0]     phase_ff, phase_in;
   logic [2:0]     hex_count_ff, hex_count_in;
   logic [15:0]    hex_value_ff, hex_value_in;
   logic [9:0]     high_part_ff, high_part_in;
   logic [LB-1:0]  count_ff, count_in;
   logic           skipping_ff, skipping_in;

   logic                  accept;
   logic                  fail_req;
   logic                  emit_req;
   logic                  nomem;
   jsu_pkg::jsu_utf8_type emit;
   jsu_pkg::jsu_hex_type  hexd;
   logic [15:0]           hv_new;
   logic [20:0]           cp_pair;
   logic [LB-1:0]         limit;
   logic [7:0]            b;
   logic                  last;

   assign b      = req_ch.in_byte;
   assign last   = req_ch.in_last;
   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && req_ch.ready;
   assign limit  = (capacity_ff == '0) ? '0 : capacity_ff - {{(LB-1){1'b0}}, 1'b1};

   always_comb begin
      phase_in     = phase_ff;
      hex_count_in = hex_count_ff;
      hex_value_in = hex_value_ff;
      high_part_in = high_part_ff;
      count_in     = count_ff;
      skipping_in  = skipping_ff;
      fail_req     = 1'b0;
      emit_req     = 1'b0;
      emit         = jsu_pkg::raw_byte(b);
      hexd         = jsu_pkg::hex_digit(b);
      hv_new       = {hex_value_ff[11:0], hexd.value};
      // 0x10000 + high * 0x400 + (low - 0xDC00)
      cp_pair      = 21'h10000 + {1'b0, high_part_ff, hv_new[9:0]};
      q_cmd.bytes    = '0;
      q_cmd.n_bytes  = 3'd0;
      q_cmd.has_done = 1'b0;
      q_cmd.status   = jsu_pkg::ST_OK;
      q_cmd.base_len = count_ff;
      nomem          = 1'b0;

      if (skipping_ff) begin
         if (last) skipping_in = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_NORMAL: begin
               if (b == CH_BSLASH) begin
                  phase_in = PH_ESC;
               end else begin
                  emit_req = 1'b1;
               end
            end
            PH_ESC: begin
               phase_in = PH_NORMAL;
               unique case (b)
                  CH_QUOTE, CH_BSLASH, CH_SLASH: emit_req = 1'b1;
                  CH_R: begin emit_req = 1'b1; emit = jsu_pkg::raw_byte(BYTE_CR); end
                  CH_N: begin emit_req = 1'b1; emit = jsu_pkg::raw_byte(BYTE_LF); end
                  CH_T: begin emit_req = 1'b1; emit = jsu_pkg::raw_byte(BYTE_TAB); end
                  CH_B: begin emit_req = 1'b1; emit = jsu_pkg::raw_byte(BYTE_BS); end
                  CH_F: begin emit_req = 1'b1; emit = jsu_pkg::raw_byte(BYTE_FF); end
                  CH_U: begin
                     phase_in     = PH_HEX1;
                     hex_count_in = 3'd0;
                     hex_value_in = 16'd0;
                  end
                  default: fail_req = 1'b1;
               endcase
            end
            PH_HEX1, PH_HEX2: begin
               if (!hexd.ok) begin
                  fail_req = 1'b1;
               end else begin
                  hex_value_in = hv_new;
                  hex_count_in = hex_count_ff + 3'd1;
                  if (hex_count_ff == 3'd3) begin
                     phase_in = PH_NORMAL;
                     if (phase_ff == PH_HEX2) begin
                        if (hv_new >= 16'hDC00 && hv_new <= 16'hDFFF) begin
                           emit_req = 1'b1;
                           emit     = jsu_pkg::utf8_encode(cp_pair);
                        end else begin
                           fail_req = 1'b1;
                        end
                     end else if (hv_new >= 16'hD800 && hv_new <= 16'hDBFF) begin
                        high_part_in = hv_new[9:0];
                        phase_in     = PH_WANT_BS;
                     end else if (hv_new >= 16'hDC00 && hv_new <= 16'hDFFF) begin
                        fail_req = 1'b1;   // lone low surrogate
                     end else begin
                        emit_req = 1'b1;
                        emit     = jsu_pkg::utf8_encode({5'd0, hv_new});
                     end
                  end
               end
            end
            PH_WANT_BS: begin
               if (b == CH_BSLASH) phase_in = PH_WANT_U;
               else fail_req = 1'b1;
            end
            PH_WANT_U: begin
               if (b == CH_U) begin
                  phase_in     = PH_HEX2;
                  hex_count_in = 3'd0;
                  hex_value_in = 16'd0;
               end else begin
                  fail_req = 1'b1;
               end
            end
            default: fail_req = 1'b1;
         endcase

         // whole character or nothing
         nomem = emit_req &&
                 (({1'b0, count_ff} + {{(LB-2){1'b0}}, emit.n}) > {1'b0, limit});

         if (fail_req || nomem) begin
            q_cmd.has_done = 1'b1;
            q_cmd.status   = nomem ? jsu_pkg::ST_NOMEM : jsu_pkg::ST_BAD;
            skipping_in    = !last;
         end else begin
            if (emit_req) begin
               q_cmd.bytes   = emit.bytes;
               q_cmd.n_bytes = emit.n;
               count_in      = count_ff + {{(LB-3){1'b0}}, emit.n};
            end
            if (last) begin
               q_cmd.has_done = 1'b1;
               q_cmd.status   = (phase_in != PH_NORMAL) ? jsu_pkg::ST_BAD : jsu_pkg::ST_OK;
            end
         end

         if (q_cmd.has_done) begin
            phase_in     = PH_NORMAL;
            hex_count_in = 3'd0;
            hex_value_in = 16'd0;
            high_part_in = 10'd0;
            count_in     = '0;
         end
      end
   end

   assign q_push = accept && (q_cmd.n_bytes != 3'd0 || q_cmd.has_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= '1;
         phase_ff     <= PH_NORMAL;
         hex_count_ff <= 3'd0;
         hex_value_ff <= 16'd0;
         high_part_ff <= 10'd0;
         count_ff     <= '0;
         skipping_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) capacity_ff <= csr_wr_data;
         if (accept) begin
            phase_ff     <= phase_in;
            hex_count_ff <= hex_count_in;
            hex_value_ff <= hex_value_in;
            high_part_ff <= high_part_in;
            count_ff     <= count_in;
            skipping_ff  <= skipping_in;
         end
      end
   end

   a_cmd_shape: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_cmd.n_bytes <= 3'd4) && (q_cmd.n_bytes != 3'd0 || q_cmd.has_done))
      else $error("queue command with bad byte count");

   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      q_push && q_cmd.has_done && q_cmd.status != jsu_pkg::ST_OK |-> q_cmd.n_bytes == 3'd0)
      else $error("error result carries data bytes");

   a_skip_after_err: assert property (@(posedge clock) disable iff (reset)
      q_push && q_cmd.has_done && q_cmd.status != jsu_pkg::ST_OK && !last
      |=> skipping_ff && phase_ff == PH_NORMAL)
      else $error("error before last byte did not start skipping");

endmodule

FILE: rtl/jsu_fifo.sv
// Short command queue between front and back end.
module jsu_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  jsu_pkg::jsu_cmd_type  push_data,
   output logic                  full,
   input  logic                  pop,
   output jsu_pkg::jsu_cmd_type  pop_data,
   output logic                  empty
);

   localparam int PB = jsu_pkg::FIFO_PTR_BITS;
   localparam int CB = jsu_pkg::FIFO_CNT_BITS;

   jsu_pkg::jsu_cmd_type entry_ff [jsu_pkg::FIFO_DEPTH];
   logic [PB-1:0] wr_ptr_ff;
   logic [PB-1:0] rd_ptr_ff;
   logic [CB-1:0] count_ff;

   assign full     = (count_ff == CB'(jsu_pkg::FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + {{(PB-1){1'b0}}, 1'b1};
         if (pop)  rd_ptr_ff <= rd_ptr_ff + {{(PB-1){1'b0}}, 1'b1};
         if (push && !pop)      count_ff <= count_ff + {{(CB-1){1'b0}}, 1'b1};
         else if (pop && !push) count_ff <= count_ff - {{(CB-1){1'b0}}, 1'b1};
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push |-> !full || pop) and (pop |-> !empty))
      else $error("queue overrun or underrun");

endmodule

FILE: rtl/jsu_back.sv
// Back end: plays out the results of the queued commands, one response per beat.
module jsu_back (
   input  logic                  clock,
   input  logic                  reset,
   input  jsu_pkg::jsu_cmd_type  q_head,
   input  logic                  q_empty,
   output logic                  q_pop,
   jsu_rsp_if.source             rsp_ch
);

   localparam int LB = jsu_pkg::LEN_BITS;

   jsu_pkg::jsu_cmd_type cur_ff;
   logic                 cur_valid_ff;
   logic [2:0]           idx_ff;

   logic [2:0] total;
   logic       is_data;
   logic       last_res;
   logic       rsp_fire;
   logic [2:0] len_add;

   assign total    = cur_ff.n_bytes + {2'd0, cur_ff.has_done};
   assign is_data  = idx_ff < cur_ff.n_bytes;
   assign last_res = (idx_ff == total - 3'd1);
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign q_pop    = !q_empty && (!cur_valid_ff || (rsp_fire && last_res));
   assign len_add  = is_data ? idx_ff + 3'd1 : idx_ff;

   assign rsp_ch.valid      = cur_valid_ff;
   assign rsp_ch.out_byte   = is_data ? cur_ff.bytes[idx_ff[1:0]] : 8'd0;
   assign rsp_ch.out_valid  = is_data;
   assign rsp_ch.done_res   = !is_data;
   assign rsp_ch.status     = is_data ? jsu_pkg::ST_OK : cur_ff.status;
   assign rsp_ch.out_length = cur_ff.base_len + {{(LB-3){1'b0}}, len_add};

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_head;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else if (q_pop) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= 3'd0;
      end else if (rsp_fire) begin
         if (last_res) begin
            cur_valid_ff <= 1'b0;
            idx_ff       <= 3'd0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> idx_ff < total)
      else $error("result index past end of command");

endmodule
